@@ sv/tdq_pkg.sv @@
// Shared types, widths and constants for the tail-drop queue delay model.
// Used by tdq_ram, tdq_depart and tail_drop_queue_delay_model; no dependencies.

package tdq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int TIME_W  = 56;
    localparam int SIZE_W  = 16;
    localparam int RATE_W  = 24;
    localparam int TX_W    = SIZE_W + RATE_W;
    localparam int LIMIT_W = 8;
    localparam int OCC_W   = 8;
    localparam int TOTAL_W = 32;
    localparam int DELAY_W = 64;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PS_PER_BYTE  = 1'b1;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(800000);

    // Request kinds.
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    // One queue entry: scheduled departure and the sojourn it will add on retirement.
    typedef struct packed {
        logic [TIME_W-1:0] dep;
        logic [TIME_W-1:0] soj;
    } entry_t;

    // Write request into the entry memory.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } wr_req_t;

    // Circular increment of a queue index.
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

endpackage

@@ sv/tdq_ram.sv @@
// Entry memory of the queue: one write port, one read port, registered read data.
// Depends on tdq_pkg for entry_t, wr_req_t and the depth.

module tdq_ram
    import tdq_pkg::*;
(
    input  logic             clk,
    input  wr_req_t          wr_req,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [QUEUE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/tdq_depart.sv @@
// Departure scheduler: transmission time, start of service, departure and sojourn.
// Depends on tdq_pkg for the time, size and rate widths.

module tdq_depart
    import tdq_pkg::*;
(
    input  logic              clk,
    input  logic [TIME_W-1:0] arrival,
    input  logic [TIME_W-1:0] last_dep,
    input  logic [SIZE_W-1:0] size,
    input  logic [RATE_W-1:0] rate,
    output logic [TIME_W-1:0] dep,
    output logic [TIME_W-1:0] soj
);

    logic [TX_W-1:0]   tx_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] wait_reg;
    logic [TIME_W:0]   dep_sum;
    logic              dep_sat;

    // Transmission time and start of service, recomputed every cycle from held inputs.
    always_ff @(posedge clk)
    begin
        tx_reg <= TX_W'(size) * TX_W'(rate);
        if (last_dep > arrival)
        begin
            start_reg <= last_dep;
            wait_reg  <= last_dep - arrival;
        end
        else
        begin
            start_reg <= arrival;
            wait_reg  <= '0;
        end
    end

    // Saturating departure; the sojourn follows the same saturation.
    always_comb
    begin
        dep_sum = {1'b0, start_reg} + (TIME_W + 1)'(tx_reg);
        dep_sat = dep_sum[TIME_W];
        if (dep_sat)
        begin
            dep = '1;
            soj = ~arrival;
        end
        else
        begin
            dep = dep_sum[TIME_W-1:0];
            soj = wait_reg + TIME_W'(tx_reg);
        end
    end

endmodule

@@ sv/tail_drop_queue_delay_model.sv @@
// Top level of the tail-drop output buffer with queueing-delay accounting.
// Depends on tdq_pkg, tdq_ram and tdq_depart.
//
//   Channel   Handshake            Payload
//   request   start / busy         kind, arrival_time, packet_size
//   result    done (one cycle)     accepted, departure_time, occupancy,
//                                  dropped_total, retired_total, total_delay
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request passes through a check state, then a finish state. In check, the
// head entry, read through the memory read port, retires at one entry per
// cycle on a flush, and on an arrival while the head departs by the arrival
// time. Finish enqueues or drops an arrival. The result strobe comes in the
// cycle after finish, when busy is low. Reset clears the queue pointers,
// counters and totals at once, not the memory. Results cannot be stalled.

module tail_drop_queue_delay_model
    import tdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [SIZE_W-1:0]     packet_size,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  accepted,
    output logic [TIME_W-1:0]     departure_time,
    output logic [OCC_W-1:0]      occupancy,
    output logic [TOTAL_W-1:0]    dropped_total,
    output logic [TOTAL_W-1:0]    retired_total,
    output logic [DELAY_W-1:0]    total_delay
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [TOTAL_W-1:0]  drop_reg, drop_next;
    logic [TOTAL_W-1:0]  retire_reg, retire_next;
    logic                done_reg, done_next;
    logic                acc_reg, acc_next;
    logic [TIME_W-1:0]   dep_out_reg, dep_out_next;

    logic                kind_reg;
    logic [TIME_W-1:0]   arr_reg;
    logic [SIZE_W-1:0]   size_reg;

    logic                take;
    logic [IDX_W-1:0]    rd_addr;
    entry_t              head_entry;
    wr_req_t             wr_req;
    logic [TIME_W-1:0]   new_dep;
    logic [TIME_W-1:0]   new_soj;
    logic [DELAY_W:0]    delay_sum;
    logic                full;
    logic [CMP_W-1:0]    fill_wide;

    assign busy      = (state_reg != ST_IDLE);
    assign take      = start && !busy;
    assign cfg_ready = 1'b1;

    // Result ports come straight from the state registers.
    assign fill_wide      = CMP_W'(fill_reg);
    assign done           = done_reg;
    assign accepted       = acc_reg;
    assign departure_time = dep_out_reg;
    assign occupancy      = fill_wide[OCC_W-1:0];
    assign dropped_total  = drop_reg;
    assign retired_total  = retire_reg;
    assign total_delay    = delay_reg;

    // Entry memory and departure scheduler.
    tdq_ram u_ram (
        .clk     (clk),
        .wr_req  (wr_req),
        .rd_addr (rd_addr),
        .rd_data (head_entry)
    );

    tdq_depart u_depart (
        .clk      (clk),
        .arrival  (arr_reg),
        .last_dep (last_reg),
        .size     (size_reg),
        .rate     (rate_reg),
        .dep      (new_dep),
        .soj      (new_soj)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BUFFER_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_PS_PER_BYTE:  rate_reg  <= cfg_data[RATE_W-1:0];
                default:          limit_reg <= limit_reg;
            endcase
        end
    end

    // Request payload is held for the whole request.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind;
            arr_reg  <= arrival_time;
            size_reg <= packet_size;
        end
    end

    // Buffer full at the limit or at the queue depth, whichever is lower.
    assign full = (fill_wide >= CMP_W'(QUEUE_DEPTH)) || (fill_wide >= CMP_W'(limit_reg));

    // Saturating delay accumulation of the entry at the head.
    assign delay_sum = {1'b0, delay_reg} + (DELAY_W + 1)'(head_entry.soj);

    // Sequencer: retire from the head, then enqueue or drop an arrival.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        last_next    = last_reg;
        delay_next   = delay_reg;
        drop_next    = drop_reg;
        retire_next  = retire_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        dep_out_next = dep_out_reg;
        wr_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (kind_reg == KIND_FLUSH || head_entry.dep <= arr_reg)
                begin
                    delay_next = delay_sum[DELAY_W] ? '1 : delay_sum[DELAY_W-1:0];
                    if (retire_reg != '1)
                    begin
                        retire_next = retire_reg + 1'b1;
                    end
                    head_next = next_slot(head_reg);
                    fill_next = fill_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                acc_next     = 1'b0;
                dep_out_next = '0;
                if (kind_reg == KIND_ARRIVAL)
                begin
                    if (!full)
                    begin
                        wr_req.en       = 1'b1;
                        wr_req.addr     = tail_reg;
                        wr_req.data.dep = new_dep;
                        wr_req.data.soj = new_soj;
                        tail_next       = next_slot(tail_reg);
                        fill_next       = fill_reg + 1'b1;
                        last_next       = new_dep;
                        acc_next        = 1'b1;
                        dep_out_next    = new_dep;
                    end
                    else if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The head is read ahead, at the index it will hold next, so the registered data matches it.
    assign rd_addr = head_next;

    // Control state and totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            last_reg   <= '0;
            delay_reg  <= '0;
            drop_reg   <= '0;
            retire_reg <= '0;
            done_reg   <= 1'b0;
            acc_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            last_reg   <= last_next;
            delay_reg  <= delay_next;
            drop_reg   <= drop_next;
            retire_reg <= retire_next;
            done_reg   <= done_next;
            acc_reg    <= acc_next;
        end
    end

    // Departure shown with the result.
    always_ff @(posedge clk)
    begin
        dep_out_reg <= dep_out_next;
    end

endmodule

@@ bench/tdq_delay_checker.sv @@
// Checker for the tail-drop queue delay model: watches the request, register and result
// channels, predicts each result and compares it with what the block reports.
// Depends on tdq_pkg.

module tdq_delay_checker
    import tdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  kind,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [SIZE_W-1:0]     packet_size,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  done,
    input  logic                  accepted,
    input  logic [TIME_W-1:0]     departure_time,
    input  logic [OCC_W-1:0]      occupancy,
    input  logic [TOTAL_W-1:0]    dropped_total,
    input  logic [TOTAL_W-1:0]    retired_total,
    input  logic [DELAY_W-1:0]    total_delay,
    output int                    mismatch_count,
    output int                    reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // One result of the block, in port order.
    typedef struct packed {
        logic               accepted;
        logic [TIME_W-1:0]  departure;
        logic [OCC_W-1:0]   occupancy;
        logic [TOTAL_W-1:0] drops;
        logic [TOTAL_W-1:0] retires;
        logic [DELAY_W-1:0] delay;
    } queue_report_t;

    // Shadow copy of the buffer, its counters and the two registers.
    logic [TIME_W-1:0]  arr_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0]  dep_mem [QUEUE_DEPTH];
    int unsigned        head_pos;
    int unsigned        tail_pos;
    int unsigned        fill;
    logic [TIME_W-1:0]  last_dep;
    logic [DELAY_W-1:0] delay_acc;
    logic [TOTAL_W-1:0] drop_cnt;
    logic [TOTAL_W-1:0] retire_cnt;
    logic [LIMIT_W-1:0] limit_reg;
    logic [RATE_W-1:0]  rate_reg;

    queue_report_t awaited_reports [$];
    queue_report_t want;
    queue_report_t got;

    // Remove the oldest packet and add its sojourn to the saturating delay total.
    function automatic void retire_oldest();
        logic [DELAY_W-1:0] sojourn;
        logic [DELAY_W:0]   sum;
        sojourn = (dep_mem[head_pos] >= arr_mem[head_pos])
                ? DELAY_W'(dep_mem[head_pos] - arr_mem[head_pos]) : '0;
        sum = {1'b0, delay_acc} + sojourn;
        delay_acc = sum[DELAY_W] ? '1 : sum[DELAY_W-1:0];
        if (retire_cnt != '1)
            retire_cnt++;
        head_pos = (head_pos == QUEUE_DEPTH - 1) ? 0 : head_pos + 1;
        fill--;
    endfunction

    // Apply one request to the shadow buffer and return the result it should give.
    function automatic queue_report_t queue_outcome(input logic k,
                                                    input logic [TIME_W-1:0] t,
                                                    input logic [SIZE_W-1:0] sz);
        queue_report_t      rep;
        int unsigned        room;
        logic [DELAY_W-1:0] base;
        logic [DELAY_W-1:0] tx;
        rep = '0;
        room = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_reg;
        if (k == KIND_FLUSH)
        begin
            while (fill > 0)
                retire_oldest();
        end
        else
        begin
            while (fill > 0 && dep_mem[head_pos] <= t)
                retire_oldest();
            if (fill < room)
            begin
                base = (last_dep > t) ? last_dep : t;
                tx = DELAY_W'(sz) * DELAY_W'(rate_reg);
                last_dep = (base > DELAY_W'(TIME_MAX) - tx) ? TIME_MAX : TIME_W'(base + tx);
                arr_mem[tail_pos] = t;
                dep_mem[tail_pos] = last_dep;
                tail_pos = (tail_pos == QUEUE_DEPTH - 1) ? 0 : tail_pos + 1;
                fill++;
                rep.accepted = 1'b1;
                rep.departure = last_dep;
            end
            else if (drop_cnt != '1)
            begin
                drop_cnt++;
            end
        end
        rep.occupancy = OCC_W'(fill);
        rep.drops = drop_cnt;
        rep.retires = retire_cnt;
        rep.delay = delay_acc;
        return rep;
    endfunction

    // Track register writes, check results against the oldest prediction, predict requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_pos = 0;
            tail_pos = 0;
            fill = 0;
            last_dep = '0;
            delay_acc = '0;
            drop_cnt = '0;
            retire_cnt = '0;
            limit_reg = LIMIT_RESET;
            rate_reg = RATE_RESET;
            awaited_reports.delete();
            mismatch_count = 0;
            reports_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BUFFER_LIMIT)
                    limit_reg = cfg_data[LIMIT_W-1:0];
                else if (cfg_index == CFG_PS_PER_BYTE)
                    rate_reg = cfg_data;
            end

            if (done)
            begin
                if (awaited_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result strobe with no request outstanding", $realtime);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    got = {accepted, departure_time, occupancy,
                           dropped_total, retired_total, total_delay};
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: result differs from prediction", $realtime);
                            $display("  expected acc %0d dep %h occ %0d drop %0d ret %0d delay %h",
                                     want.accepted, want.departure, want.occupancy,
                                     want.drops, want.retires, want.delay);
                            $display("  actual   acc %0d dep %h occ %0d drop %0d ret %0d delay %h",
                                     got.accepted, got.departure, got.occupancy,
                                     got.drops, got.retires, got.delay);
                        end
                    end
                end
            end

            // Predictions join the back of the queue of awaited results.
            if (start && !busy)
                awaited_reports.insert(awaited_reports.size(),
                                       queue_outcome(kind, arrival_time, packet_size));
            reports_owed <= awaited_reports.size();
        end
    end

endmodule

@@ bench/tail_drop_queue_delay_model_tb.sv @@
// Top of the tail-drop queue delay model testbench: clock, reset, request and register
// stimulus, and the final verdict. Depends on tdq_pkg, tdq_delay_checker and the block.

module tail_drop_queue_delay_model_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdq_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 95;
    localparam int SAT_ROUNDS  = 3;

    // Register settings of the random phases; the last two rates and last limit are drawn.
    localparam int unsigned PHASE_LIMIT [NUM_PHASES] = '{128, 3, 255, 16, 1, 0, 0};
    localparam int unsigned PHASE_RATE  [NUM_PHASES] = '{1, 24'hFFFFFF, 800000, 0, 1000, 0, 0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  kind = KIND_ARRIVAL;
    logic [TIME_W-1:0]     arrival_time = '0;
    logic [SIZE_W-1:0]     packet_size = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BUFFER_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  cfg_ready;
    logic                  done;
    logic                  accepted;
    logic [TIME_W-1:0]     departure_time;
    logic [OCC_W-1:0]      occupancy;
    logic [TOTAL_W-1:0]    dropped_total;
    logic [TOTAL_W-1:0]    retired_total;
    logic [DELAY_W-1:0]    total_delay;
    int                    mismatch_count;
    int                    reports_owed;

    logic                  no_gaps = 1'b0;
    logic [RATE_W-1:0]     rate_now = RATE_RESET;
    logic [TIME_W-1:0]     now = '0;

    always #4 clk = ~clk;

    tail_drop_queue_delay_model DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .arrival_time   (arrival_time),
        .packet_size    (packet_size),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .accepted       (accepted),
        .departure_time (departure_time),
        .occupancy      (occupancy),
        .dropped_total  (dropped_total),
        .retired_total  (retired_total),
        .total_delay    (total_delay)
    );

    tdq_delay_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .arrival_time   (arrival_time),
        .packet_size    (packet_size),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .accepted       (accepted),
        .departure_time (departure_time),
        .occupancy      (occupancy),
        .dropped_total  (dropped_total),
        .retired_total  (retired_total),
        .total_delay    (total_delay),
        .mismatch_count (mismatch_count),
        .reports_owed   (reports_owed)
    );

    // Issue one request after a random gap; start stays high so a following request
    // with no gap goes out back to back.
    task automatic send_request(input logic k, input logic [TIME_W-1:0] t,
                                input logic [SIZE_W-1:0] sz);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        arrival_time <= t;
        packet_size <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop issuing and wait until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (reports_owed != 0)
            @(posedge clk);
    endtask

    // Write one register once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int unsigned gap;
        wait_drained();
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Limit writes carry random upper bits, which the register ignores.
    task automatic write_limit(input int unsigned lim);
        write_reg(CFG_BUFFER_LIMIT, {16'($urandom), 8'(lim)});
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        rate_now = rate;
        write_reg(CFG_PS_PER_BYTE, rate);
    endtask

    initial begin : stimulus
        int unsigned lim;
        int unsigned r;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, largest size, back-to-back queueing, flushes (also of an
        // empty buffer), decreasing timestamps, zero rate, zero limit, limit of one,
        // limit above the depth and the largest rate.
        send_request(KIND_ARRIVAL, '0, '0);
        send_request(KIND_ARRIVAL, '0, '1);
        send_request(KIND_ARRIVAL, TIME_W'(1), SIZE_W'(1));
        send_request(KIND_FLUSH, TIME_MAX, '1);
        send_request(KIND_FLUSH, '0, '0);
        send_request(KIND_ARRIVAL, TIME_W'(1000000), SIZE_W'(100));
        send_request(KIND_ARRIVAL, TIME_W'(10), SIZE_W'(5));
        write_rate('0);
        send_request(KIND_ARRIVAL, TIME_W'(20), SIZE_W'(500));
        write_limit(0);
        send_request(KIND_ARRIVAL, TIME_W'(30), SIZE_W'(9));
        send_request(KIND_ARRIVAL, TIME_MAX, SIZE_W'(9));
        write_limit(1);
        write_rate(RATE_W'(1));
        send_request(KIND_FLUSH, '0, '0);
        send_request(KIND_ARRIVAL, TIME_W'(100), SIZE_W'(7));
        send_request(KIND_ARRIVAL, TIME_W'(100), SIZE_W'(7));
        write_limit(255);
        write_rate('1);
        send_request(KIND_ARRIVAL, 56'h55_5555_5555_5555, 16'hAAAA);
        send_request(KIND_ARRIVAL, 56'hAA_AAAA_AAAA_AAAA, 16'h5555);
        send_request(KIND_FLUSH, '0, '0);

        // Random phases: mostly advancing arrivals with bursts, some flushes and some
        // arrivals that go back in time.
        now = 56'hB0_0000_0000_0000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            lim = (p == NUM_PHASES - 1) ? $urandom_range(2, 64) : PHASE_LIMIT[p];
            write_limit(lim);
            write_rate((p >= NUM_PHASES - 2) ? RATE_W'($urandom) : RATE_W'(PHASE_RATE[p]));
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_request(KIND_FLUSH, TIME_W'({$urandom, $urandom}), SIZE_W'($urandom));
                end else if (r < 9) begin
                    send_request(KIND_ARRIVAL, now - TIME_W'($urandom_range(1, 1 << 20)),
                                 SIZE_W'($urandom));
                end else begin
                    if (r >= 40)
                        now = now + TIME_W'(64'($urandom_range(0, 300)) * rate_now
                                            + $urandom_range(0, 7));
                    send_request(KIND_ARRIVAL, now,
                                 ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                                             : SIZE_W'($urandom_range(0, 255)));
                end
            end
        end

        // Saturation: push the departure clock to its ceiling, then fill the buffer with
        // early arrivals so that every retirement adds a huge sojourn and the delay total
        // saturates. A full buffer drops the extra arrivals.
        write_limit(QUEUE_DEPTH);
        write_rate(RATE_W'($urandom_range(1, 24'hFFFFFF)));
        for (int rnd = 0; rnd < SAT_ROUNDS; rnd++) begin
            no_gaps = ($urandom_range(0, 1) == 0);
            send_request(KIND_ARRIVAL, TIME_MAX - TIME_W'($urandom_range(0, 1000)), '1);
            for (int j = 0; j < QUEUE_DEPTH; j++)
                send_request(KIND_ARRIVAL, TIME_W'($urandom_range(0, 1000)), SIZE_W'($urandom));
            if (rnd % 2 == 0)
                send_request(KIND_FLUSH, '0, '0);
            else
                send_request(KIND_ARRIVAL, TIME_MAX, '0);
        end

        // Let the last result arrive, then give a stray strobe time to show up.
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && reports_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #3_200_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ tail_drop_queue_delay_model.f @@
sv/tdq_pkg.sv
sv/tdq_ram.sv
sv/tdq_depart.sv
sv/tail_drop_queue_delay_model.sv
bench/tdq_delay_checker.sv
bench/tail_drop_queue_delay_model_tb.sv
